// ===== design/rsp_pkg.sv =====
// Package for the radix string parser: phase codes, state and result types, digit decode.
`default_nettype none
package rsp_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] PhDone   = 3'd0;
  localparam logic [PhaseW-1:0] PhLead   = 3'd1;
  localparam logic [PhaseW-1:0] PhSigned = 3'd2;
  localparam logic [PhaseW-1:0] PhZero   = 3'd3;
  localparam logic [PhaseW-1:0] PhDigits = 3'd4;

  localparam logic [BaseW-1:0] RadixReset = 6'd10;
  localparam logic [BaseW-1:0] RadixAuto  = 6'd0;
  localparam logic [BaseW-1:0] Base8      = 6'd8;
  localparam logic [BaseW-1:0] Base10     = 6'd10;
  localparam logic [BaseW-1:0] Base16     = 6'd16;
  localparam logic [BaseW-1:0] BaseMin    = 6'd2;
  localparam logic [BaseW-1:0] BaseMax    = 6'd36;
  localparam logic [BaseW-1:0] NotDigit   = 6'd63;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChLoX   = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ValueW-1:0] accum;
    logic [BaseW-1:0]  base;
    logic              minus;
  } rsp_state_t;

  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] value;
    logic              minus_seen;
  } rsp_result_t;

  // Digit value of an alphanumeric byte; NotDigit is above every legal base.
  function automatic logic [BaseW-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NotDigit);
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = c - ChUpA + 8'd10;
    end else if (c >= ChLoA && c <= ChLoZ) begin
      d = c - ChLoA + 8'd10;
    end
    return d[BaseW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/rsp_if.sv =====
// Valid/ready channel interfaces for the character input and the value result.
`default_nettype none
interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, output ch, output first, input ready);
  modport sink (input valid, input ch, input first, output ready);
endinterface

interface rsp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        minus_seen;

  modport source (output valid, output value, output minus_seen, input ready);
  modport sink (input valid, input value, input minus_seen, output ready);
endinterface
`default_nettype wire

// ===== design/rsp_step.sv =====
// Next-state and result logic for one character of the parser.
`default_nettype none
module rsp_step (
  input  rsp_pkg::rsp_state_t             state_i,
  input  logic [rsp_pkg::BaseW-1:0]       radix_i,
  input  logic [7:0]                      ch_i,
  input  logic                            first_i,
  output rsp_pkg::rsp_state_t             state_o,
  output rsp_pkg::rsp_result_t            result_o
);
  import rsp_pkg::*;

  rsp_state_t     cur;
  logic           is_digit_step;
  logic [BaseW-1:0] dig_base;
  logic [BaseW-1:0] dig_val;
  logic           dig_ok;
  logic           prefix_ok;
  logic [ValueW-1:0] mac;

  assign dig_val   = digit_of(ch_i);
  assign prefix_ok = (radix_i == RadixAuto) || (radix_i == Base16);
  assign dig_ok    = (dig_base >= BaseMin) && (dig_base <= BaseMax) && (dig_val < dig_base);
  assign mac       = cur.accum * ValueW'(dig_base) + ValueW'(dig_val);

  always_comb begin
    cur = state_i;
    if (first_i) begin
      cur.phase = PhLead;
      cur.accum = '0;
      cur.base  = '0;
      cur.minus = 1'b0;
    end

    state_o       = cur;
    is_digit_step = 1'b0;
    dig_base      = cur.base;

    case (cur.phase)
      PhLead, PhSigned: begin
        if (cur.phase == PhLead && (ch_i == ChSpace || ch_i == ChTab)) begin
          state_o = cur;
        end else if (cur.phase == PhLead && ch_i == ChMinus) begin
          state_o.minus = 1'b1;
          state_o.phase = PhSigned;
        end else if (cur.phase == PhLead && ch_i == ChPlus) begin
          state_o.phase = PhSigned;
        end else if (prefix_ok && ch_i == ChZero) begin
          state_o.phase = PhZero;
        end else begin
          dig_base      = (radix_i == RadixAuto) ? Base10 : radix_i;
          is_digit_step = 1'b1;
        end
      end
      PhZero: begin
        // The leading zero itself adds nothing; in auto mode the next byte decides the base.
        cur.accum     = '0;
        state_o.accum = '0;
        state_o.phase = PhDigits;
        if (ch_i == ChLoX || ch_i == ChUpX) begin
          state_o.base = Base16;
        end else begin
          dig_base      = (radix_i == RadixAuto) ? Base8 : Base16;
          is_digit_step = 1'b1;
        end
      end
      PhDigits: begin
        is_digit_step = 1'b1;
      end
      default: begin
        state_o = cur;
      end
    endcase

    result_o.emit       = 1'b0;
    result_o.value      = cur.accum;
    result_o.minus_seen = cur.minus;
    if (is_digit_step) begin
      state_o.base = dig_base;
      if (dig_ok) begin
        state_o.phase = PhDigits;
        state_o.accum = mac;
      end else begin
        state_o.phase = PhDone;
        result_o.emit = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/radix_string_to_u64_parser_unit.sv =====
// Top level of the streaming string to unsigned 64-bit parser.
//
// Characters arrive on in_chan, one per item, with first marking the start
// of a string. Each accepted item lands in an input register; once out_chan
// is not stalled, the parse logic updates the parse state from it and,
// when the item ends the number, loads the result register that drives
// out_chan. One item is taken every cycle while out_chan is not stalled;
// the single 64 by 6 multiply-add per character is the path that sets the
// clock.
// The radix register is written through cfg_we_i/cfg_wdata_i; the user must
// do so only while the unit is idle, as the unit does not enforce this.
// 0 selects the base from the prefix. Reset clears the radix to 10, empties
// both registers and leaves the parser waiting for a first character. When
// out_chan stalls with a result held, the input register keeps its item and
// in_chan.ready drops only once that register is full as well.
`default_nettype none
module radix_string_to_u64_parser_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rsp_pkg::BaseW-1:0]  cfg_wdata_i,
  rsp_in_if.sink                     in_chan,
  rsp_out_if.source                  out_chan
);
  import rsp_pkg::*;

  logic [BaseW-1:0]  radix_q;
  logic              in_vq;
  logic [7:0]        ch_q;
  logic              first_q;
  rsp_state_t        state_q, state_d;
  rsp_result_t       result;
  logic              out_vq;
  logic [ValueW-1:0] value_q;
  logic              minus_q;
  logic              proc;

  assign proc          = in_vq && (!out_vq || out_chan.ready);
  assign in_chan.ready = !in_vq || proc;

  rsp_step u_step (
    .state_i  (state_q),
    .radix_i  (radix_q),
    .ch_i     (ch_q),
    .first_i  (first_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= RadixReset;
      in_vq         <= 1'b0;
      out_vq        <= 1'b0;
      state_q.phase <= PhDone;
      state_q.accum <= '0;
      state_q.base  <= '0;
      state_q.minus <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (in_chan.ready) begin
        in_vq <= in_chan.valid;
      end
      if (proc) begin
        state_q <= state_d;
        out_vq  <= result.emit;
      end else if (out_chan.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.ready && in_chan.valid) begin
      ch_q    <= in_chan.ch;
      first_q <= in_chan.first;
    end
    if (proc && result.emit) begin
      value_q <= result.value;
      minus_q <= result.minus_seen;
    end
  end

  assign out_chan.valid      = out_vq;
  assign out_chan.value      = value_q;
  assign out_chan.minus_seen = minus_q;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming string to unsigned 64-bit parser.
`timescale 1ns / 100ps
module tb_top;
  import rsp_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned PhaseItems   = 82;
  localparam int unsigned NumPhases    = 11;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              minus_seen;
  } parse_result_t;

  typedef struct {
    logic [BaseW-1:0]  radix;
    bit                start;
    string             text;
    bit                known;
    bit                emits;
    logic [ValueW-1:0] value;
    bit                minus;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [BaseW-1:0] cfg_wdata_i;

  rsp_in_if  in_chan ();
  rsp_out_if out_chan ();

  radix_string_to_u64_parser_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_chan    (in_chan),
    .out_chan   (out_chan)
  );

  always #6 clk_i = ~clk_i;

  // Parser state as the testbench tracks it, starting from the reset values.
  logic [BaseW-1:0]  cur_radix = RadixReset;
  logic [PhaseW-1:0] par_phase = PhDone;
  logic [ValueW-1:0] par_accum = '0;
  logic [BaseW-1:0]  par_base  = '0;
  logic              par_minus = 1'b0;

  parse_result_t parsed_q[$];
  int unsigned   mismatches = 0;
  int unsigned   chars_sent = 0;
  int unsigned   cycle_cnt  = 0;
  bit            tx_idle_en = 1'b0;
  bit            rx_idle_en = 1'b0;
  bit            hold_req   = 1'b0;

  // A '$' in the text stands for the NUL terminator.
  dir_row_t dir_rows [11] = '{
    '{Base10,    1'b1, "$",       1'b1, 1'b1, 64'd0, 1'b0},
    '{Base10,    1'b0, "7",       1'b1, 1'b0, 64'd0, 1'b0},
    '{Base10,    1'b1, " \t-9A",  1'b1, 1'b1, 64'd9, 1'b1},
    '{Base10,    1'b1, "53",      1'b1, 1'b0, 64'd0, 1'b0},
    '{Base10,    1'b1, "+ ",      1'b1, 1'b1, 64'd0, 1'b0},
    '{Base10,    1'b1, "1\377",   1'b1, 1'b1, 64'd1, 1'b0},
    '{Base16,    1'b1, "0xg",     1'b1, 1'b1, 64'd0, 1'b0},
    '{RadixAuto, 1'b1, "017$",    1'b0, 1'b0, 64'd0, 1'b0},
    '{6'd1,      1'b1, "5",       1'b1, 1'b1, 64'd0, 1'b0},
    '{6'd37,     1'b1, "-z",      1'b1, 1'b1, 64'd0, 1'b1},
    '{BaseMax,   1'b1, "Zz$",     1'b0, 1'b0, 64'd0, 1'b0}
  };

  // Typed expectations travel with the item that is on the channel.
  bit                note_known = 1'b0;
  bit                note_emits = 1'b0;
  logic [ValueW-1:0] note_value = '0;
  bit                note_minus = 1'b0;

  function automatic int char_digit(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChUpA && c <= ChUpZ) return int'(c - ChUpA) + 10;
    if (c >= ChLoA && c <= ChLoZ) return int'(c - ChLoA) + 10;
    return 99;
  endfunction

  function automatic void digit_step(input logic [7:0] c, output logic emit,
                                     output parse_result_t r);
    int d;
    d = char_digit(c);
    emit = 1'b0;
    r = '0;
    if (par_base >= BaseMin && par_base <= BaseMax && d < int'(par_base)) begin
      par_accum = par_accum * 64'(par_base) + 64'(d);
    end else begin
      emit = 1'b1;
      r = '{value: par_accum, minus_seen: par_minus};
      par_phase = PhDone;
    end
  endfunction

  function automatic void begin_number(input logic [7:0] c, output logic emit,
                                       output parse_result_t r);
    emit = 1'b0;
    r = '0;
    if ((cur_radix == RadixAuto || cur_radix == Base16) && c == ChZero) begin
      par_phase = PhZero;
    end else begin
      par_base = (cur_radix == RadixAuto) ? Base10 : cur_radix;
      par_phase = PhDigits;
      digit_step(c, emit, r);
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic f,
                                     output logic emit, output parse_result_t r);
    emit = 1'b0;
    r = '0;
    if (f) begin
      par_phase = PhLead;
      par_accum = '0;
      par_base  = '0;
      par_minus = 1'b0;
    end
    case (par_phase)
      PhLead: begin
        if (c == ChMinus) begin
          par_minus = 1'b1;
          par_phase = PhSigned;
        end else if (c == ChPlus) begin
          par_phase = PhSigned;
        end else if (c != ChSpace && c != ChTab) begin
          begin_number(c, emit, r);
        end
      end
      PhSigned: begin
        begin_number(c, emit, r);
      end
      PhZero: begin
        par_accum = '0;
        par_phase = PhDigits;
        if (c == ChLoX || c == ChUpX) begin
          par_base = Base16;
        end else begin
          par_base = (cur_radix == RadixAuto) ? Base8 : Base16;
          digit_step(c, emit, r);
        end
      end
      PhDigits: begin
        digit_step(c, emit, r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : scoreboard
    logic          emit;
    parse_result_t r;
    parse_result_t e;
    if (in_chan.valid && in_chan.ready) begin
      parse_char(in_chan.ch, in_chan.first, emit, r);
      if (note_known) begin
        if (note_emits) parsed_q.push_back('{value: note_value, minus_seen: note_minus});
      end else if (emit) begin
        parsed_q.push_back(r);
      end
    end
    if (out_chan.valid && out_chan.ready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result: value %h, minus_seen %b", out_chan.value,
               out_chan.minus_seen);
        mismatches++;
      end else begin
        e = parsed_q.pop_front();
        if (out_chan.value !== e.value) begin
          $error("value: expected %h, actual %h", e.value, out_chan.value);
          mismatches++;
        end
        if (out_chan.minus_seen !== e.minus_seen) begin
          $error("minus_seen: expected %b, actual %b", e.minus_seen, out_chan.minus_seen);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_chan.ready = 1'b0;
      end else if (hold_req) begin
        out_chan.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(3) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(4)) @(negedge clk_i);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  task automatic drive_char(input logic [7:0] c, input logic f, input bit known = 1'b0,
                            input bit emits = 1'b0, input logic [ValueW-1:0] val = '0,
                            input bit minus = 1'b0);
    if (tx_idle_en && $urandom_range(5) == 0) begin
      @(negedge clk_i);
      in_chan.valid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_chan.valid = 1'b1;
    in_chan.ch    = c;
    in_chan.first = f;
    note_known = known;
    note_emits = emits;
    note_value = val;
    note_minus = minus;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
  endtask

  // Waits until every result is in and the pipeline has gone quiet, then writes.
  task automatic set_radix(input logic [BaseW-1:0] r);
    @(negedge clk_i);
    in_chan.valid = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = r;
    cur_radix   = r;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + 8'(d);
    return ($urandom_range(1) ? ChUpA : ChLoA) + 8'(d - 10);
  endfunction

  task automatic send_random_string();
    logic [7:0]  s[$];
    int unsigned kind;
    int unsigned eff;
    int unsigned n_digits;
    kind = $urandom_range(9);
    if (kind == 0) begin
      // Noise: raw bytes with random string starts.
      repeat ($urandom_range(6, 1)) begin
        drive_char(8'($urandom), 1'($urandom));
        chars_sent++;
      end
      return;
    end
    repeat ($urandom_range(2)) s.push_back($urandom_range(1) ? ChSpace : ChTab);
    case ($urandom_range(3))
      0: s.push_back(ChMinus);
      1: s.push_back(ChPlus);
      default: ;
    endcase
    eff = (cur_radix >= BaseMin && cur_radix <= BaseMax) ? cur_radix : 36;
    if (cur_radix == RadixAuto || cur_radix == Base16) begin
      case ($urandom_range(2))
        0: eff = (cur_radix == RadixAuto) ? 10 : 16;
        1: begin
          s.push_back(ChZero);
          eff = (cur_radix == RadixAuto) ? 8 : 16;
        end
        default: begin
          s.push_back(ChZero);
          s.push_back($urandom_range(1) ? ChLoX : ChUpX);
          eff = 16;
        end
      endcase
    end
    // Long digit runs can make the value wrap past 64 bits.
    n_digits = ($urandom_range(7) == 0) ? $urandom_range(24, 12) : $urandom_range(6);
    repeat (n_digits) s.push_back(digit_char($urandom_range(eff - 1)));
    // A string cut short here is restarted mid-parse by the next one.
    if (kind != 1) begin
      case ($urandom_range(3))
        0, 1: s.push_back(8'h00);
        2: s.push_back(ChSpace);
        default: s.push_back(8'($urandom));
      endcase
    end
    foreach (s[k]) drive_char(s[k], k == 0);
    chars_sent += s.size();
    if (kind == 2) begin
      repeat ($urandom_range(3, 1)) drive_char(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    logic [BaseW-1:0] phase_radix [NumPhases];
    string            txt;
    logic [7:0]       c;
    int unsigned      phase_end;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_chan.valid  = 1'b0;
    in_chan.ch     = '0;
    in_chan.first  = 1'b0;
    phase_radix = '{Base10, RadixAuto, Base16, BaseMax, BaseMin, Base8, 6'd1, 6'd37,
                    6'd63, 6'($urandom_range(63)), RadixAuto};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].radix != cur_radix) set_radix(dir_rows[i].radix);
      txt = dir_rows[i].text;
      for (int k = 0; k < txt.len(); k++) begin
        c = (txt[k] == "$") ? 8'h00 : txt[k];
        drive_char(c, (k == 0) ? dir_rows[i].start : 1'b0, dir_rows[i].known,
                   dir_rows[i].emits && (k == txt.len() - 1), dir_rows[i].value,
                   dir_rows[i].minus);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      set_radix(phase_radix[p]);
      // The receiver holds off while strings keep coming, so the unit backs up.
      if (p == 3) hold_req = 1'b1;
      phase_end = chars_sent + PhaseItems;
      while (chars_sent < phase_end) send_random_string();
    end

    @(negedge clk_i);
    in_chan.valid = 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rsp_pkg.sv
design/rsp_if.sv
design/rsp_step.sv
design/radix_string_to_u64_parser_unit.sv
tb/tb_top.sv
